>>> design/rgbmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbmm_pkg
// Shared constants and types for the RGB min/max contrast stretch block.
// ----------------------------------------------------------------------------
package rgbmm_pkg;

  // frame store geometry
  localparam int MAX_PIXELS = 4096;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int CNT_W      = ADDR_W + 1;

  // sample and result widths
  localparam int SAMPLE_W   = 32;
  localparam int BYTE_W     = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = NUM_CH * SAMPLE_W;
  localparam int SCALED_W   = SAMPLE_W + BYTE_W;
  localparam int STEP_W     = $clog2(BYTE_W);

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  // channel index codes
  typedef logic [1:0] chan_t;
  localparam chan_t CH_RED   = 2'd0;
  localparam chan_t CH_GREEN = 2'd1;
  localparam chan_t CH_BLUE  = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_SETUP = 4'b0100,
    S_DIV   = 4'b1000
  } state_t;

endpackage

>>> design/rgb_minmax_contrast_stretch_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_minmax_contrast_stretch_top
// Stores an RGB frame, tracks per-channel min/max, and reads pixels back
// stretched to 0..255 with floor(255*(v-min)/(max-min)) per channel.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------------
//  input    | in_cmd in_first in_red in_green in_blue | start & !busy
//  result   | out_red_byte out_green_byte             | out_valid, one cycle
//           | out_blue_byte out_last                  |
//
//  a load never raises busy: the store write and extrema update happen at the
//  accept edge. an emit on a non-empty frame holds busy through one store
//  read, then per channel one range setup, one scale step and 8 restoring
//  divide steps on the shared 34-bit subtractor; out_valid pulses in the
//  cycle in which busy drops. an emit on an empty frame gives no result and
//  does not raise busy. reset is synchronous, active low, and needs no
//  clearing pass. the receiver cannot stall the result.
// ----------------------------------------------------------------------------
module rgb_minmax_contrast_stretch_top
  import rgbmm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_cmd,
  input  logic                       in_first,
  input  logic signed [SAMPLE_W-1:0] in_red,
  input  logic signed [SAMPLE_W-1:0] in_green,
  input  logic signed [SAMPLE_W-1:0] in_blue,
  output logic                       out_valid,
  output logic [BYTE_W-1:0]          out_red_byte,
  output logic [BYTE_W-1:0]          out_green_byte,
  output logic [BYTE_W-1:0]          out_blue_byte,
  output logic                       out_last
);

  // frame store
  logic [PIX_W-1:0] mem [MAX_PIXELS];
  logic [PIX_W-1:0] rd_data_r;

  // control state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   wp_r, wp_nxt;
  logic [ADDR_W-1:0]  rp_r, rp_nxt;
  chan_t              ch_r, ch_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  // extrema
  logic signed [SAMPLE_W-1:0] min_r [NUM_CH];
  logic signed [SAMPLE_W-1:0] max_r [NUM_CH];

  // datapath registers
  logic [SAMPLE_W-1:0] dif_r, dif_nxt;
  logic [SAMPLE_W-1:0] rng_r, rng_nxt;
  logic                zero_r, zero_nxt;
  logic                scaled_r, scaled_nxt;
  logic [SAMPLE_W-1:0] rem_r, rem_nxt;
  logic [BYTE_W-1:0]   low_r, low_nxt;
  logic [BYTE_W-1:0]   quo_r, quo_nxt;
  logic [BYTE_W-1:0]   red_r, green_r, blue_r;
  logic [BYTE_W-1:0]   byte_nxt;
  logic                byte_we;
  logic                last_r, last_nxt;

  // accept decode
  logic               accept, do_load, do_emit;
  logic [CNT_W-1:0]   wp_base;
  logic               load_ok;
  logic [ADDR_W-1:0]  rp_eff;
  logic               emit_last;
  logic [SAMPLE_W-1:0] in_s [NUM_CH];

  // per-channel operands
  logic signed [SAMPLE_W-1:0] cur_v, cur_lo, cur_hi;
  logic signed [SAMPLE_W:0]   d_wide, r_wide;
  logic [SAMPLE_W-1:0]        dif_clamp;
  logic [SCALED_W-1:0]        scaled;
  logic [SAMPLE_W+1:0]        trial;
  logic                       qbit;

  assign accept  = start && !busy;
  assign do_load = accept && (in_cmd == CMD_LOAD);
  assign do_emit = accept && (in_cmd == CMD_EMIT) && (wp_r != '0);

  assign in_s[0] = in_red;
  assign in_s[1] = in_green;
  assign in_s[2] = in_blue;

  // load target and emit read address
  assign wp_base   = in_first ? '0 : wp_r;
  assign load_ok   = wp_base < CNT_W'(MAX_PIXELS);
  assign rp_eff    = ({1'b0, rp_r} >= wp_r) ? '0 : rp_r;
  assign emit_last = ({1'b0, rp_eff} + CNT_W'(1)) >= wp_r;

  // channel operand select
  always_comb begin
    unique case (ch_r)
      CH_RED: begin
        cur_v  = rd_data_r[SAMPLE_W-1:0];
        cur_lo = min_r[0];
        cur_hi = max_r[0];
      end
      CH_GREEN: begin
        cur_v  = rd_data_r[2*SAMPLE_W-1:SAMPLE_W];
        cur_lo = min_r[1];
        cur_hi = max_r[1];
      end
      default: begin
        cur_v  = rd_data_r[3*SAMPLE_W-1:2*SAMPLE_W];
        cur_lo = min_r[2];
        cur_hi = max_r[2];
      end
    endcase
  end

  // offset and range of the current channel
  assign d_wide = {cur_v[SAMPLE_W-1], cur_v} - {cur_lo[SAMPLE_W-1], cur_lo};
  assign r_wide = {cur_hi[SAMPLE_W-1], cur_hi} - {cur_lo[SAMPLE_W-1], cur_lo};

  // 255 * min(diff, range)
  assign dif_clamp = (dif_r > rng_r) ? rng_r : dif_r;
  assign scaled    = {dif_clamp, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, dif_clamp};

  // restoring divide step on the shared subtractor
  assign trial = {1'b0, rem_r, low_r[BYTE_W-1]} - {2'b00, rng_r};
  assign qbit  = !trial[SAMPLE_W+1];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    ch_nxt        = ch_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    dif_nxt       = dif_r;
    rng_nxt       = rng_r;
    zero_nxt      = zero_r;
    scaled_nxt    = scaled_r;
    rem_nxt       = rem_r;
    low_nxt       = low_r;
    quo_nxt       = quo_r;
    last_nxt      = last_r;
    byte_nxt      = '0;
    byte_we       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (do_load) begin
          if (in_first) begin
            rp_nxt = '0;
            wp_nxt = '0;
          end
          if (load_ok) begin
            wp_nxt = wp_base + CNT_W'(1);
          end
        end else if (do_emit) begin
          last_nxt  = emit_last;
          rp_nxt    = emit_last ? '0 : rp_eff + ADDR_W'(1);
          ch_nxt    = CH_RED;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        // first pass: offset and range; second pass: scale into the divider
        if (!scaled_r) begin
          dif_nxt    = d_wide[SAMPLE_W-1:0];
          rng_nxt    = r_wide[SAMPLE_W-1:0];
          zero_nxt   = d_wide[SAMPLE_W] || (d_wide == '0) ||
                       r_wide[SAMPLE_W] || (r_wide == '0);
          scaled_nxt = 1'b1;
        end else begin
          rem_nxt    = scaled[SCALED_W-1:BYTE_W];
          low_nxt    = scaled[BYTE_W-1:0];
          quo_nxt    = '0;
          cnt_nxt    = '0;
          scaled_nxt = 1'b0;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = qbit ? trial[SAMPLE_W-1:0] : {rem_r[SAMPLE_W-2:0], low_r[BYTE_W-1]};
        low_nxt = {low_r[BYTE_W-2:0], 1'b0};
        quo_nxt = {quo_r[BYTE_W-2:0], qbit};
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(BYTE_W - 1)) begin
          byte_we  = 1'b1;
          byte_nxt = zero_r ? '0 : {quo_r[BYTE_W-2:0], qbit};
          if (ch_r == CH_BLUE) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = S_SETUP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      ch_r        <= CH_RED;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      scaled_r    <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        min_r[c] <= '0;
        max_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      ch_r        <= ch_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      scaled_r    <= scaled_nxt;
      // running extrema, restarted on the first pixel of a frame
      if (do_load && load_ok) begin
        for (int c = 0; c < NUM_CH; c++) begin
          if (wp_base == '0) begin
            min_r[c] <= in_s[c];
            max_r[c] <= in_s[c];
          end else begin
            if ($signed(in_s[c]) < min_r[c]) min_r[c] <= in_s[c];
            if ($signed(in_s[c]) > max_r[c]) max_r[c] <= in_s[c];
          end
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    dif_r  <= dif_nxt;
    rng_r  <= rng_nxt;
    zero_r <= zero_nxt;
    rem_r  <= rem_nxt;
    low_r  <= low_nxt;
    quo_r  <= quo_nxt;
    last_r <= last_nxt;
    if (byte_we) begin
      case (ch_r)
        CH_RED:   red_r   <= byte_nxt;
        CH_GREEN: green_r <= byte_nxt;
        default:  blue_r  <= byte_nxt;
      endcase
    end
  end

  // frame store write and registered read
  always_ff @(posedge clk) begin
    if (do_load && load_ok) begin
      mem[wp_base[ADDR_W-1:0]] <= {in_blue, in_green, in_red};
    end
    if (do_emit) begin
      rd_data_r <= mem[rp_eff];
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_red_byte   = red_r;
  assign out_green_byte = green_r;
  assign out_blue_byte  = blue_r;
  assign out_last       = last_r;

`ifndef SYNTHESIS
  // a result transaction is a single-cycle pulse
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  // an emit on a non-empty frame starts the sequencer
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    do_emit |=> busy)
    else $error("emit accepted without going busy");

  // fill count never exceeds the store depth
  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= CNT_W'(MAX_PIXELS))
    else $error("write pointer beyond store depth");

  // read pointer stays inside the filled part of the frame
  a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, rp_r} < wp_r) || (rp_r == '0))
    else $error("read pointer outside filled frame");

  // a result only follows the last divide step of the blue channel
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_DIV) && ($past(ch_r) == CH_BLUE))
    else $error("result strobe without finished divide");
`endif

endmodule

>>> tb/stretch_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stretch_monitor
// Watches the command and result channels of the contrast stretch block.
// Keeps its own copy of the frame, the per-channel extrema and the read
// position. For every accepted emit it computes the stretched pixel and
// compares it field by field with the next result the block produces.
// ----------------------------------------------------------------------------
module stretch_monitor
  import rgbmm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       in_cmd,
  input  logic                       in_first,
  input  logic signed [SAMPLE_W-1:0] in_red,
  input  logic signed [SAMPLE_W-1:0] in_green,
  input  logic signed [SAMPLE_W-1:0] in_blue,
  input  logic                       out_valid,
  input  logic [BYTE_W-1:0]          out_red_byte,
  input  logic [BYTE_W-1:0]          out_green_byte,
  input  logic [BYTE_W-1:0]          out_blue_byte,
  input  logic                       out_last,
  output int                         fail_count,
  output int                         pending
);

  typedef struct {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              last;
  } stretched_pixel_t;

  // mirror of the frame store and the running extrema
  logic signed [SAMPLE_W-1:0] frame_mem [MAX_PIXELS][NUM_CH];
  logic signed [SAMPLE_W-1:0] ch_lo [NUM_CH];
  logic signed [SAMPLE_W-1:0] ch_hi [NUM_CH];
  int unsigned                pixel_cnt;
  int unsigned                read_idx;
  stretched_pixel_t           expected_pixels [$];

  // floor(255 * (v - lo) / (hi - lo)), flat channel gives 0
  function automatic logic [BYTE_W-1:0] stretch_channel(longint v, longint lo, longint hi);
    longint span;
    longint offs;
    longint q;
    if (hi <= lo || v <= lo) return '0;
    span = hi - lo;
    offs = v - lo;
    if (offs > span) offs = span;
    q = (longint'(255) * offs) / span;
    if (q > 255) q = 255;
    return q[BYTE_W-1:0];
  endfunction

  // update the mirror for one accepted transaction
  task automatic predict_transaction();
    logic signed [SAMPLE_W-1:0] smp [NUM_CH];
    stretched_pixel_t           px;
    smp[CH_RED]   = in_red;
    smp[CH_GREEN] = in_green;
    smp[CH_BLUE]  = in_blue;
    if (in_cmd == CMD_LOAD) begin
      if (in_first) begin
        pixel_cnt = 0;
        read_idx  = 0;
      end
      // a full store drops further loads
      if (pixel_cnt < MAX_PIXELS) begin
        for (int c = 0; c < NUM_CH; c++) begin
          if (pixel_cnt == 0) begin
            ch_lo[c] = smp[c];
            ch_hi[c] = smp[c];
          end else begin
            if (smp[c] < ch_lo[c]) ch_lo[c] = smp[c];
            if (smp[c] > ch_hi[c]) ch_hi[c] = smp[c];
          end
          frame_mem[pixel_cnt][c] = smp[c];
        end
        pixel_cnt++;
      end
    end else if (pixel_cnt != 0) begin
      // emit: empty frame gives nothing
      if (read_idx >= pixel_cnt) read_idx = 0;
      px.red   = stretch_channel(frame_mem[read_idx][CH_RED], ch_lo[CH_RED], ch_hi[CH_RED]);
      px.green = stretch_channel(frame_mem[read_idx][CH_GREEN], ch_lo[CH_GREEN],
                                 ch_hi[CH_GREEN]);
      px.blue  = stretch_channel(frame_mem[read_idx][CH_BLUE], ch_lo[CH_BLUE], ch_hi[CH_BLUE]);
      px.last  = (read_idx + 1 >= pixel_cnt);
      read_idx = px.last ? 0 : read_idx + 1;
      expected_pixels.insert(expected_pixels.size(), px);
    end
  endtask

  function automatic void check_field(string name, logic [BYTE_W-1:0] want,
                                      logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // compare one result against the oldest prediction
  task automatic compare_result();
    stretched_pixel_t want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected result: out_red_byte %0d out_green_byte %0d %s %0d out_last %0d",
             out_red_byte, out_green_byte, "out_blue_byte", out_blue_byte, out_last);
      fail_count++;
      return;
    end
    want = expected_pixels.pop_front();
    check_field("out_red_byte", want.red, out_red_byte);
    check_field("out_green_byte", want.green, out_green_byte);
    check_field("out_blue_byte", want.blue, out_blue_byte);
    check_field("out_last", want.last, out_last);
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      pixel_cnt = 0;
      read_idx  = 0;
      for (int c = 0; c < NUM_CH; c++) begin
        ch_lo[c] = '0;
        ch_hi[c] = '0;
      end
      expected_pixels.delete();
    end else begin
      if (start && !busy) predict_transaction();
      if (out_valid) compare_result();
    end
    pending = expected_pixels.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and emit commands into the contrast stretch block: a short
// directed sequence, then many small random frames with emits, appended
// loads and restarts.
// The monitor beside the block predicts and checks every result.
// ----------------------------------------------------------------------------
module testbench;
  import rgbmm_pkg::*;

  logic                       clk      = 1'b0;
  logic                       rst_n    = 1'b0;
  logic                       start    = 1'b0;
  logic                       in_cmd   = CMD_LOAD;
  logic                       in_first = 1'b0;
  logic signed [SAMPLE_W-1:0] in_red   = '0;
  logic signed [SAMPLE_W-1:0] in_green = '0;
  logic signed [SAMPLE_W-1:0] in_blue  = '0;
  logic                       busy;
  logic                       out_valid;
  logic [BYTE_W-1:0]          out_red_byte;
  logic [BYTE_W-1:0]          out_green_byte;
  logic [BYTE_W-1:0]          out_blue_byte;
  logic                       out_last;
  int                         fail_count;
  int                         pending;

  // idle pattern and per-frame sample style
  int                         quiet_left = 0;
  bit                         quiet      = 1'b0;
  int                         sent_items = 0;
  int                         frame_mode [NUM_CH];
  logic [SAMPLE_W-1:0]        frame_base [NUM_CH];

  rgb_minmax_contrast_stretch_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_first       (in_first),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_red_byte   (out_red_byte),
    .out_green_byte (out_green_byte),
    .out_blue_byte  (out_blue_byte),
    .out_last       (out_last)
  );

  stretch_monitor u_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_first       (in_first),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_red_byte   (out_red_byte),
    .out_green_byte (out_green_byte),
    .out_blue_byte  (out_blue_byte),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // one transaction: optional idle gap, then hold start until accepted
  task automatic issue(input logic cmd, input logic first_flag,
                       input logic [SAMPLE_W-1:0] r, input logic [SAMPLE_W-1:0] g,
                       input logic [SAMPLE_W-1:0] b);
    int gap;
    if (quiet_left == 0) begin
      quiet      = ($urandom_range(0, 3) == 0);
      quiet_left = $urandom_range(5, 40);
    end
    quiet_left--;
    gap = quiet ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    in_cmd   <= cmd;
    in_first <= first_flag;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_items++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(int mode, logic [SAMPLE_W-1:0] base);
    case (mode)
      0: return $urandom;
      1: return base + $urandom_range(0, 300);
      2: return base;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return base;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // per channel: full random, narrow spread, flat, or extremes mix
  task automatic pick_frame_style();
    for (int c = 0; c < NUM_CH; c++) begin
      frame_mode[c] = $urandom_range(0, 3);
      frame_base[c] = $urandom;
    end
  endtask

  task automatic load_random(input logic first_flag);
    issue(CMD_LOAD, first_flag, pick_sample(frame_mode[CH_RED], frame_base[CH_RED]),
          pick_sample(frame_mode[CH_GREEN], frame_base[CH_GREEN]),
          pick_sample(frame_mode[CH_BLUE], frame_base[CH_BLUE]));
  endtask

  initial begin
    int frame_len;
    int op_cnt;
    int roll;

    // reset
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed: emit on empty frame gives nothing
    issue(CMD_EMIT, 1'b1, 32'h0, 32'h0, 32'h0);
    // load without first on empty frame starts it; extremes on each channel
    issue(CMD_LOAD, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0005);
    issue(CMD_LOAD, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0005);
    issue(CMD_LOAD, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0005);
    // readout wraps after the last pixel, first is ignored on emits
    repeat (4) issue(CMD_EMIT, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    // append between emits
    issue(CMD_LOAD, 1'b0, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0005);
    repeat (3) issue(CMD_EMIT, 1'b0, 32'h0, 32'h0, 32'h0);
    // single-pixel frame: every channel flat, every result is last
    issue(CMD_LOAD, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    repeat (2) issue(CMD_EMIT, 1'b0, 32'h0, 32'h0, 32'h0);
    // fractional q16.16 values with mid-range quotients
    issue(CMD_LOAD, 1'b1, 32'h0001_0000, 32'h0000_0000, 32'hffff_0000);
    issue(CMD_LOAD, 1'b0, 32'h0002_0000, 32'h0000_0001, 32'h0001_0000);
    issue(CMD_LOAD, 1'b0, 32'h0001_8000, 32'h0000_0003, 32'h0000_0000);
    repeat (3) issue(CMD_EMIT, 1'b0, 32'h0, 32'h0, 32'h0);

    // random small frames with emits, appended loads and restarts
    while (sent_items < 750) begin
      pick_frame_style();
      frame_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
      load_random(1'b1);
      repeat (frame_len - 1) load_random(1'b0);
      op_cnt = $urandom_range(1, 2 * frame_len + 3);
      repeat (op_cnt) begin
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          issue(CMD_EMIT, 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
        end else if (roll < 92) begin
          load_random(1'b0);
        end else begin
          load_random(1'b1);
        end
      end
    end

    // drain and verdict
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
